### rtl/core/cds_pkg.sv
// Package for the calendar date stepper: widths, codes and calendar helper functions.
package cds_pkg;

	localparam int YEAR_MAX = 9999;

	localparam int REQ_W  = 2;
	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CENT_W = 8;
	localparam int YY_W   = 7;
	localparam int WD_W   = 3;
	localparam int ST_W   = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD = 2'd0,
		REQ_FWD  = 2'd1,
		REQ_BACK = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_LIMIT   = 2'd2
	} status_t;

	// A year is kept as century and year of century, so the leap test needs no division.
	function automatic logic is_leap(input logic [CENT_W-1:0] cent, input logic [YY_W-1:0] yy);
		if (yy == '0) begin
			return cent[1:0] == 2'd0;
		end
		return yy[1:0] == 2'd0;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Quotient by 100 through a reciprocal; exact for every 14-bit year.
	function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
		logic [26:0] p;
		p = 27'(y) * 27'd5243;
		return p[26:19];
	endfunction

	function automatic logic [WD_W-1:0] weekday_of(input logic [DAY_W-1:0] d,
			input logic [MON_W-1:0] m, input logic [CENT_W-1:0] cent,
			input logic [YY_W-1:0] yy);
		logic [2:0]  mo;
		logic [1:0]  coff;
		logic        leap;
		logic [8:0]  s;
		logic [16:0] p;
		logic [6:0]  q;
		logic [8:0]  r;
		leap = is_leap(cent, yy);
		unique case (m)
			4'd1:  mo = leap ? 3'd6 : 3'd0;
			4'd2:  mo = leap ? 3'd2 : 3'd3;
			4'd3:  mo = 3'd3;
			4'd4:  mo = 3'd6;
			4'd5:  mo = 3'd1;
			4'd6:  mo = 3'd4;
			4'd7:  mo = 3'd6;
			4'd8:  mo = 3'd2;
			4'd9:  mo = 3'd5;
			4'd10: mo = 3'd0;
			4'd11: mo = 3'd3;
			4'd12: mo = 3'd5;
			default: mo = 3'd0;
		endcase
		coff = 2'd3 - cent[1:0];
		s = 9'({coff, 1'b0}) + 9'(yy) + 9'(yy >> 2) + 9'(mo) + 9'(d);
		p = 17'(s) * 17'd147;
		q = p[16:10];
		r = s - 9'(10'(q) * 10'd7);
		if (r >= 9'd7) begin
			r = r - 9'd7;
		end
		return r[WD_W-1:0];
	endfunction

endpackage

### rtl/core/cds_req_if.sv
// Request channel: one word carries a request code and a date to load.
interface cds_req_if;
	logic                          valid;
	logic                          ready;
	logic [cds_pkg::REQ_W-1:0]     req_type;
	logic [cds_pkg::DAY_W-1:0]     load_day;
	logic [cds_pkg::MON_W-1:0]     load_month;
	logic [cds_pkg::YEAR_W-1:0]    load_year;

	modport source(output valid, req_type, load_day, load_month, load_year, input ready);
	modport sink(input valid, req_type, load_day, load_month, load_year, output ready);
endinterface

### rtl/core/cds_rsp_if.sv
// Result channel: one word carries the held date, its day of week and a status.
interface cds_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cds_pkg::DAY_W-1:0]     cur_day_out;
	logic [cds_pkg::MON_W-1:0]     cur_month_out;
	logic [cds_pkg::YEAR_W-1:0]    cur_year_out;
	logic [cds_pkg::WD_W-1:0]      weekday;
	logic [cds_pkg::ST_W-1:0]      status;

	modport source(output valid, cur_day_out, cur_month_out, cur_year_out, weekday, status,
		input ready);
	modport sink(input valid, cur_day_out, cur_month_out, cur_year_out, weekday, status,
		output ready);
endinterface

### rtl/core/calendar_date_stepper.sv
// Calendar date stepper: holds a Gregorian date and loads or steps it as each request word asks.
//
// The block takes one request word per clock cycle while the result side does not stall,
// and returns one result word for each, in order; a result word passes through stages s1,
// s2, s3 and s4 before it is presented. Each stage holds a word and passes it on as soon as
// the next stage is free, so an empty stage still takes a word while a result waits to be
// taken. The rate of one word per cycle is set by the date update stage, which reads and
// writes the held day, month and year registers in the same cycle. The year is also kept
// as century and year of century, so the leap-year test needs no division.
module calendar_date_stepper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	cds_req_if.sink    req,
	cds_rsp_if.source  rsp
);

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic                          valid_s1;
	cds_pkg::req_t                 req_s1;
	logic [cds_pkg::DAY_W-1:0]     day_s1;
	logic [cds_pkg::MON_W-1:0]     mon_s1;
	logic [cds_pkg::YEAR_W-1:0]    year_s1;

	logic                          valid_s2;
	cds_pkg::req_t                 req_s2;
	logic [cds_pkg::DAY_W-1:0]     day_s2;
	logic [cds_pkg::MON_W-1:0]     mon_s2;
	logic [cds_pkg::YEAR_W-1:0]    year_s2;
	logic [cds_pkg::CENT_W-1:0]    cent_s2;
	logic [cds_pkg::YY_W-1:0]      yy_s2;

	logic                          valid_s3;
	logic [cds_pkg::DAY_W-1:0]     day_s3;
	logic [cds_pkg::MON_W-1:0]     mon_s3;
	logic [cds_pkg::YEAR_W-1:0]    year_s3;
	logic [cds_pkg::CENT_W-1:0]    cent_s3;
	logic [cds_pkg::YY_W-1:0]      yy_s3;
	cds_pkg::status_t              status_s3;

	logic                          valid_s4;
	logic [cds_pkg::DAY_W-1:0]     day_s4;
	logic [cds_pkg::MON_W-1:0]     mon_s4;
	logic [cds_pkg::YEAR_W-1:0]    year_s4;
	logic [cds_pkg::WD_W-1:0]      weekday_s4;
	cds_pkg::status_t              status_s4;

	logic                          step_unit_q;
	logic [cds_pkg::DAY_W-1:0]     day_q;
	logic [cds_pkg::MON_W-1:0]     mon_q;
	logic [cds_pkg::YEAR_W-1:0]    year_q;
	logic [cds_pkg::CENT_W-1:0]    cent_q;
	logic [cds_pkg::YY_W-1:0]      yy_q;

	logic [cds_pkg::DAY_W-1:0]     nxt_day;
	logic [cds_pkg::MON_W-1:0]     nxt_mon;
	logic [cds_pkg::YEAR_W-1:0]    nxt_year;
	logic [cds_pkg::CENT_W-1:0]    nxt_cent;
	logic [cds_pkg::YY_W-1:0]      nxt_yy;
	cds_pkg::status_t              nxt_status;

	logic [cds_pkg::YEAR_W-1:0]    year_inc, year_dec;
	logic [cds_pkg::CENT_W-1:0]    cent_inc, cent_dec;
	logic [cds_pkg::YY_W-1:0]      yy_inc, yy_dec;
	logic                          leap_cur, leap_inc, leap_dec, leap_load;
	logic [cds_pkg::DAY_W-1:0]     len_cur, len_prev, len_load;
	logic                          load_bad, at_max, at_min;

	localparam logic [cds_pkg::YEAR_W-1:0] YEAR_TOP = cds_pkg::YEAR_W'(cds_pkg::YEAR_MAX);

	assign rdy_s4    = !valid_s4 || rsp.ready;
	assign rdy_s3    = !valid_s3 || rdy_s4;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_unit_q <= 1'b0;
		end else if (cfg_we) begin
			step_unit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= req.valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			req_s1  <= cds_pkg::req_t'(req.req_type);
			day_s1  <= req.load_day;
			mon_s1  <= req.load_month;
			year_s1 <= req.load_year;
		end
		if (rdy_s2) begin
			req_s2  <= req_s1;
			day_s2  <= day_s1;
			mon_s2  <= mon_s1;
			year_s2 <= year_s1;
			cent_s2 <= cds_pkg::div100(year_s1);
			yy_s2   <= cds_pkg::YY_W'(year_s1 - cds_pkg::YEAR_W'(
				16'(cds_pkg::div100(year_s1)) * 16'd100));
		end
		if (rdy_s3) begin
			day_s3    <= nxt_day;
			mon_s3    <= nxt_mon;
			year_s3   <= nxt_year;
			cent_s3   <= nxt_cent;
			yy_s3     <= nxt_yy;
			status_s3 <= nxt_status;
		end
		if (rdy_s4) begin
			day_s4     <= day_s3;
			mon_s4     <= mon_s3;
			year_s4    <= year_s3;
			weekday_s4 <= cds_pkg::weekday_of(day_s3, mon_s3, cent_s3, yy_s3);
			status_s4  <= status_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q  <= cds_pkg::DAY_W'(1);
			mon_q  <= cds_pkg::MON_W'(1);
			year_q <= cds_pkg::YEAR_W'(2000);
			cent_q <= cds_pkg::CENT_W'(20);
			yy_q   <= '0;
		end else if (valid_s2 && rdy_s3) begin
			day_q  <= nxt_day;
			mon_q  <= nxt_mon;
			year_q <= nxt_year;
			cent_q <= nxt_cent;
			yy_q   <= nxt_yy;
		end
	end

	always_comb begin
		year_inc  = year_q + 1'b1;
		year_dec  = year_q - 1'b1;
		yy_inc    = (yy_q == 7'd99) ? '0 : yy_q + 1'b1;
		cent_inc  = (yy_q == 7'd99) ? cent_q + 1'b1 : cent_q;
		yy_dec    = (yy_q == '0) ? 7'd99 : yy_q - 1'b1;
		cent_dec  = (yy_q == '0) ? cent_q - 1'b1 : cent_q;
		leap_cur  = cds_pkg::is_leap(cent_q, yy_q);
		leap_inc  = cds_pkg::is_leap(cent_inc, yy_inc);
		leap_dec  = cds_pkg::is_leap(cent_dec, yy_dec);
		leap_load = cds_pkg::is_leap(cent_s2, yy_s2);
		len_cur   = cds_pkg::month_len(mon_q, leap_cur);
		len_prev  = cds_pkg::month_len(mon_q - 1'b1, leap_cur);
		len_load  = cds_pkg::month_len(mon_s2, leap_load);
		at_max    = year_q >= YEAR_TOP;
		at_min    = year_q <= cds_pkg::YEAR_W'(1);
		load_bad  = (mon_s2 < 4'd1) || (mon_s2 > 4'd12) || (year_s2 == '0) ||
			(year_s2 > YEAR_TOP) || (day_s2 == '0) || (day_s2 > len_load);
	end

	always_comb begin
		nxt_day    = day_q;
		nxt_mon    = mon_q;
		nxt_year   = year_q;
		nxt_cent   = cent_q;
		nxt_yy     = yy_q;
		nxt_status = cds_pkg::ST_OK;
		unique case (req_s2)
			cds_pkg::REQ_LOAD: begin
				if (load_bad) begin
					nxt_status = cds_pkg::ST_INVALID;
				end else begin
					nxt_day  = day_s2;
					nxt_mon  = mon_s2;
					nxt_year = year_s2;
					nxt_cent = cent_s2;
					nxt_yy   = yy_s2;
				end
			end
			cds_pkg::REQ_FWD: begin
				if (step_unit_q) begin
					if (at_max) begin
						nxt_status = cds_pkg::ST_LIMIT;
					end else begin
						nxt_year = year_inc;
						nxt_cent = cent_inc;
						nxt_yy   = yy_inc;
						if (mon_q == 4'd2 && day_q == 5'd29) begin
							nxt_mon = 4'd3;
							nxt_day = 5'd1;
						end else if (mon_q == 4'd3 && day_q == 5'd1 && leap_inc) begin
							nxt_mon = 4'd2;
							nxt_day = 5'd29;
						end
					end
				end else if (day_q >= len_cur) begin
					if (mon_q >= 4'd12) begin
						if (at_max) begin
							nxt_status = cds_pkg::ST_LIMIT;
						end else begin
							nxt_year = year_inc;
							nxt_cent = cent_inc;
							nxt_yy   = yy_inc;
							nxt_mon  = 4'd1;
							nxt_day  = 5'd1;
						end
					end else begin
						nxt_mon = mon_q + 1'b1;
						nxt_day = 5'd1;
					end
				end else begin
					nxt_day = day_q + 1'b1;
				end
			end
			cds_pkg::REQ_BACK: begin
				if (step_unit_q) begin
					if (at_min) begin
						nxt_status = cds_pkg::ST_LIMIT;
					end else begin
						nxt_year = year_dec;
						nxt_cent = cent_dec;
						nxt_yy   = yy_dec;
						if (mon_q == 4'd2 && day_q == 5'd29) begin
							nxt_mon = 4'd3;
							nxt_day = 5'd1;
						end else if (mon_q == 4'd3 && day_q == 5'd1 && leap_dec) begin
							nxt_mon = 4'd2;
							nxt_day = 5'd29;
						end
					end
				end else if (day_q <= 5'd1) begin
					if (mon_q <= 4'd1) begin
						if (at_min) begin
							nxt_status = cds_pkg::ST_LIMIT;
						end else begin
							nxt_year = year_dec;
							nxt_cent = cent_dec;
							nxt_yy   = yy_dec;
							nxt_mon  = 4'd12;
							nxt_day  = 5'd31;
						end
					end else begin
						nxt_mon = mon_q - 1'b1;
						nxt_day = len_prev;
					end
				end else begin
					nxt_day = day_q - 1'b1;
				end
			end
			cds_pkg::REQ_NONE: begin
				nxt_status = cds_pkg::ST_OK;
			end
			default: begin
				nxt_status = cds_pkg::ST_OK;
			end
		endcase
	end

	assign rsp.valid         = valid_s4;
	assign rsp.cur_day_out   = day_s4;
	assign rsp.cur_month_out = mon_s4;
	assign rsp.cur_year_out  = year_s4;
	assign rsp.weekday       = weekday_s4;
	assign rsp.status        = status_s4;

endmodule

### rtl/core/cds_checker.sv
// Checker for the calendar date stepper ports, bound to the top level.
module cds_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [cds_pkg::DAY_W-1:0]     cur_day_out,
	input logic [cds_pkg::MON_W-1:0]     cur_month_out,
	input logic [cds_pkg::YEAR_W-1:0]    cur_year_out,
	input logic [cds_pkg::WD_W-1:0]      weekday,
	input logic [cds_pkg::ST_W-1:0]      status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(cur_day_out) &&
		$stable(cur_month_out) && $stable(cur_year_out) && $stable(weekday) &&
		$stable(status))
		else $error("result word changed while stalled");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cur_day_out >= 5'd1 && cur_month_out >= 4'd1 &&
		cur_month_out <= 4'd12 && cur_year_out >= 14'd1 &&
		cur_year_out <= cds_pkg::YEAR_W'(cds_pkg::YEAR_MAX) && weekday <= 3'd6)
		else $error("held date or weekday out of range");

	a_month_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((cur_month_out == 4'd4 || cur_month_out == 4'd6 ||
		cur_month_out == 4'd9 || cur_month_out == 4'd11) ? cur_day_out <= 5'd30 :
		(cur_month_out == 4'd2) ? cur_day_out <= 5'd29 : cur_day_out <= 5'd31))
		else $error("held day beyond the length of its month");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("result valid during reset");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.cur_day_out   (rsp.cur_day_out),
	.cur_month_out (rsp.cur_month_out),
	.cur_year_out  (rsp.cur_year_out),
	.weekday       (rsp.weekday),
	.status        (rsp.status)
);
